[hdl/lpd_pkg.sv]
package lpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 32;
    localparam int HDR_BYTES = 4;
    localparam int POS_W     = $clog2(HDR_BYTES);
    localparam int USER_W    = 2;

    // header length in the counter's width
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HDR_BYTES);

    typedef enum logic
    {
        PH_HEADER,
        PH_CONTENT
    } phase_t;

    // one result as it leaves the core
    typedef struct packed
    {
        logic [BYTE_W-1:0] payload_byte;
        logic              first_of_packet;
        logic              last_of_packet;
        logic              empty_packet;
    } result_t;

endpackage

[hdl/lpd_in_stage.sv]
module lpd_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lpd_pkg::BYTE_W-1:0]  s_byte,
    input  logic                        advance,
    output logic                        hold_valid,
    output logic [lpd_pkg::BYTE_W-1:0]  hold_byte
);
    import lpd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // slot frees up when the held byte moves on in the same cycle
    assign s_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

[hdl/lpd_core.sv]
module lpd_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [lpd_pkg::BYTE_W-1:0]  item_byte,
    output logic                        res_valid,
    output lpd_pkg::result_t            res
);
    import lpd_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LEN_W-1:0]   accum_reg;
    logic [LEN_W-1:0]   accum_next;
    logic [LEN_W-1:0]   left_reg;
    logic [LEN_W-1:0]   left_next;
    logic               started_reg;
    logic               started_next;

    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   accum_merged;
    logic [LEN_W-1:0]   left_dec;
    logic               left_done;

    // byte position in the header, wraps for an out-of-range counter
    assign pos          = POS_W'(HDR_LEN - left_reg);
    assign accum_merged = accum_reg
                        | (LEN_W'(item_byte) << {pos, 3'b000});
    assign left_dec     = (left_reg != '0) ? left_reg - LEN_W'(1) : '0;
    assign left_done    = (left_dec == '0);

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        left_next    = left_reg;
        started_next = started_reg;
        if (item_valid)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    accum_next = accum_merged;
                    left_next  = left_dec;
                    if (left_done)
                    begin
                        if (accum_merged == '0)
                        begin
                            accum_next = '0;
                            left_next  = HDR_LEN;
                        end
                        else
                        begin
                            phase_next = PH_CONTENT;
                            left_next  = accum_merged;
                        end
                        started_next = 1'b0;
                    end
                end
                PH_CONTENT:
                begin
                    started_next = 1'b1;
                    left_next    = left_dec;
                    if (left_done)
                    begin
                        phase_next   = PH_HEADER;
                        accum_next   = '0;
                        left_next    = HDR_LEN;
                        started_next = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        case (phase_reg)
            PH_HEADER:
            begin
                if (item_valid && left_done && (accum_merged == '0))
                begin
                    res_valid           = 1'b1;
                    res.first_of_packet = 1'b1;
                    res.last_of_packet  = 1'b1;
                    res.empty_packet    = 1'b1;
                end
            end
            PH_CONTENT:
            begin
                res_valid           = item_valid;
                res.payload_byte    = item_byte;
                res.first_of_packet = !started_reg;
                res.last_of_packet  = left_done;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            accum_reg   <= '0;
            left_reg    <= HDR_LEN;
            started_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            left_reg    <= left_next;
            started_reg <= started_next;
        end
    end

endmodule

[hdl/lpd_out_stage.sv]
module lpd_out_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        res_valid,
    input  lpd_pkg::result_t            res,
    output logic                        free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lpd_pkg::result_t            m_res
);
    import lpd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

[hdl/length_prefixed_deframer_top.sv]
// an accepted byte passes from the input register through the combinational core into the
// result register, from which the sink takes its result
// throughput: one byte per cycle while the sink keeps m_axis_tready high
// header bytes update the length register in the core
// reset: asynchronous, active low; block starts in the header phase, both stages empty
module length_prefixed_deframer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // raw framed byte stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lpd_pkg::BYTE_W-1:0]          s_axis_tdata,   // [7:0] data_byte
    // deframed content stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lpd_pkg::BYTE_W-1:0]          m_axis_tdata,   // [7:0] payload_byte
    output logic                                m_axis_tlast,   // last_of_packet
    output logic [lpd_pkg::USER_W-1:0]          m_axis_tuser    // [0] first_of_packet,
                                                                // [1] empty_packet
);
    import lpd_pkg::*;

    logic              hold_valid;
    logic [BYTE_W-1:0] hold_byte;
    logic              out_free;
    logic              advance;
    logic              res_valid;
    result_t           res;
    result_t           m_res;

    // held byte goes through the core whenever the output register can take
    // whatever it produces; header bytes move on even if nothing is emitted
    assign advance = hold_valid && out_free;

    // input register, decouples the upstream request from the core
    lpd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_byte     (s_axis_tdata),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    // header gather, length counter and packet marks
    lpd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item_byte  (hold_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register toward the sink
    lpd_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .res_valid  (res_valid),
        .res        (res),
        .free       (out_free),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_res      (m_res)
    );

    assign m_axis_tdata = m_res.payload_byte;
    assign m_axis_tlast = m_res.last_of_packet;
    assign m_axis_tuser = {m_res.empty_packet, m_res.first_of_packet};

endmodule
